FILE: hdl/saht_pkg.sv
// shared types and constants for the set-associative hash store
// no dependencies; imported by the controller, the datapath and the top level
package saht_pkg;

   localparam int WAY_W = 2;

   typedef enum logic [0:0] {
      OP_PROBE = 1'b0,
      OP_SAVE  = 1'b1
   } opcode_type;

   localparam logic [1:0] BOUND_KIND_EXACT = 2'd3;

   // one stored entry; depth in offset form, age/pv/bound form the age byte
   typedef struct packed {
      logic [15:0] tag;
      logic [15:0] move;
      logic [15:0] value;
      logic [15:0] eval;
      logic [7:0]  depth;
      logic [4:0]  age;
      logic        pv;
      logic [1:0]  bound;
   } entry_type;

   localparam int ENTRY_W = $bits(entry_type);

   typedef enum logic [1:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_READ,
      ST_EVAL
   } state_type;

   typedef struct packed {
      logic clear_wr;
      logic load;
      logic rd_en;
      logic commit;
   } cmd_type;

   typedef struct packed {
      logic clear_last;
   } status_type;

   // replacement worth: depth minus eight times relative age
   function automatic logic signed [9:0] repl_worth(entry_type e, logic [4:0] cur_age);
      logic [7:0] age_byte;
      logic [7:0] rel;
      age_byte = {e.age, e.pv, e.bound};
      rel = (8'd7 + {cur_age, 3'b000} - age_byte) & 8'hF8;
      return $signed({2'b00, e.depth}) - $signed({2'b00, rel});
   endfunction

endpackage

FILE: hdl/saht_ram.sv
// generic single-port-write, single-port-read ram with registered read data
// no dependencies
module saht_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: hdl/saht_ctrl.sv
// controller state machine: clear sweep, item sequencing, result handshake
// depends on saht_pkg
module saht_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output saht_pkg::cmd_type    cmd,
   input  saht_pkg::status_type status
);

   import saht_pkg::*;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_ready = 1'b0;
      case (state_ff)
         ST_CLEAR: begin
            cmd.clear_wr = 1'b1;
            if (status.clear_last) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = ST_READ;
            end
         end
         ST_READ: begin
            cmd.rd_en = 1'b1;
            state_in  = ST_EVAL;
         end
         ST_EVAL: begin
            if (!rsp_valid_ff || rsp_ready) begin
               cmd.commit = 1'b1;
               state_in   = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_CLEAR;
         end
      endcase
   end

   always_comb begin
      if (cmd.commit) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   assign rsp_valid = rsp_valid_ff;

   // one item in flight at a time
   a_single_item: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> !req_ready)
      else $error("second transfer accepted while an item is in flight");

   // a result only appears from the evaluate step
   a_rsp_from_eval: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(state_ff) == ST_EVAL)
      else $error("result raised outside evaluate step");

   // a committed result is never dropped by the output register
   a_commit_shows: assert property (@(posedge clock) disable iff (reset)
      cmd.commit |=> rsp_valid)
      else $error("committed result not presented");

endmodule

FILE: hdl/saht_dp.sv
// datapath: item registers, cluster index multiply, cluster ram, way compare,
// replacement pick, save rules and result register; depends on saht_pkg, saht_ram
module saht_dp #(
   parameter int CLUSTERS   = 1024,
   parameter int WAYS       = 3,
   parameter int DEPTH_BIAS = -7
) (
   input  logic                   clock,
   input  logic                   reset,
   input  saht_pkg::cmd_type      cmd,
   output saht_pkg::status_type   status,
   input  logic                   req_opcode,
   input  logic [63:0]            req_key,
   input  logic [1:0]             req_target_way,
   input  logic signed [15:0]     req_score,
   input  logic signed [15:0]     req_static_eval,
   input  logic                   req_pv_flag,
   input  logic [1:0]             req_bound_kind,
   input  logic signed [8:0]      req_search_depth,
   input  logic [15:0]            req_best_move,
   input  logic                   csr_wr_en,
   input  logic [4:0]             csr_wr_data,
   output logic                   rsp_hit,
   output logic [1:0]             rsp_chosen_way,
   output logic [15:0]            rsp_entry_tag,
   output logic [15:0]            rsp_entry_move,
   output logic signed [15:0]     rsp_entry_value,
   output logic signed [15:0]     rsp_entry_eval,
   output logic [7:0]             rsp_entry_depth,
   output logic [1:0]             rsp_entry_bound,
   output logic                   rsp_entry_pv,
   output logic [4:0]             rsp_entry_age
);

   import saht_pkg::*;

   localparam int IDX_W  = $clog2(CLUSTERS);
   localparam int MUL_W  = 32 + $clog2(CLUSTERS + 1);
   localparam int ROW_W  = WAYS * ENTRY_W;
   localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(CLUSTERS - 1);

   // item registers
   logic             opcode_ff;
   logic [15:0]      key_tag_ff;
   logic [WAY_W-1:0] way_ff;
   logic [15:0]      score_ff;
   logic [15:0]      eval_ff;
   logic             pv_ff;
   logic [1:0]       bound_ff;
   logic [7:0]       depth8_ff, depth8_in;
   logic [15:0]      move_ff;
   logic [IDX_W-1:0] cluster_ff, cluster_in;

   logic [4:0]       search_age_ff;
   logic [IDX_W-1:0] clr_cnt_ff;

   logic [MUL_W-1:0]  prod;
   logic signed [10:0] dsum;

   // result register
   logic             res_hit_ff, res_hit_in;
   logic [WAY_W-1:0] res_way_ff, res_way_in;
   entry_type        res_entry_ff, res_entry_in;

   // cluster row
   logic [ROW_W-1:0]       ram_rd_data;
   logic [ROW_W-1:0]       ram_wr_data;
   logic [IDX_W-1:0]       ram_wr_addr;
   entry_type [WAYS-1:0]   row_rd;
   entry_type [WAYS-1:0]   row_new;

   // evaluate-step scratch
   logic               found;
   entry_type          found_e;
   logic [WAY_W-1:0]   found_idx;
   logic signed [9:0]  best_val;
   logic signed [9:0]  cur_val;
   entry_type          best_e;
   logic [WAY_W-1:0]   best_idx;
   logic               way_ok;
   entry_type          sel_e;
   entry_type          save_e;
   logic               tag_diff;
   logic               deeper;

   // cluster = (key low word * CLUSTERS) >> 32
   assign prod       = MUL_W'(req_key[31:0]) * MUL_W'(CLUSTERS);
   assign cluster_in = prod[32 +: IDX_W];

   // depth to offset form, saturated to a byte
   assign dsum = 11'(req_search_depth) + 11'(0 - DEPTH_BIAS);
   always_comb begin
      if (dsum < 11'sd0) begin
         depth8_in = 8'd0;
      end else if (dsum > 11'sd255) begin
         depth8_in = 8'hFF;
      end else begin
         depth8_in = dsum[7:0];
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         opcode_ff  <= req_opcode;
         key_tag_ff <= req_key[63:48];
         way_ff     <= req_target_way;
         score_ff   <= req_score;
         eval_ff    <= req_static_eval;
         pv_ff      <= req_pv_flag;
         bound_ff   <= req_bound_kind;
         depth8_ff  <= depth8_in;
         move_ff    <= req_best_move;
         cluster_ff <= cluster_in;
      end
      if (cmd.commit) begin
         res_hit_ff   <= res_hit_in;
         res_way_ff   <= res_way_in;
         res_entry_ff <= res_entry_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         search_age_ff <= '0;
         clr_cnt_ff    <= '0;
      end else begin
         if (csr_wr_en) begin
            search_age_ff <= csr_wr_data;
         end
         if (cmd.clear_wr) begin
            clr_cnt_ff <= clr_cnt_ff + 1'b1;
         end
      end
   end

   assign status.clear_last = (clr_cnt_ff == LAST_IDX);

   saht_ram #(
      .WIDTH (ROW_W),
      .DEPTH (CLUSTERS)
   ) u_row_ram (
      .clock   (clock),
      .wr_en   (cmd.clear_wr || cmd.commit),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_en   (cmd.rd_en),
      .rd_addr (cluster_ff),
      .rd_data (ram_rd_data)
   );

   assign row_rd      = ram_rd_data;
   assign ram_wr_addr = cmd.clear_wr ? clr_cnt_ff : cluster_ff;
   assign ram_wr_data = cmd.clear_wr ? '0 : ROW_W'(row_new);

   // probe: first empty or matching way, else lowest replacement worth
   always_comb begin
      found     = 1'b0;
      found_e   = row_rd[0];
      found_idx = '0;
      for (int i = 0; i < WAYS; i++) begin
         if (!found && (row_rd[i].tag == 16'd0 || row_rd[i].tag == key_tag_ff)) begin
            found     = 1'b1;
            found_e   = row_rd[i];
            found_idx = WAY_W'(i);
         end
      end
      found_e.age = search_age_ff;

      best_e   = row_rd[0];
      best_idx = '0;
      best_val = repl_worth(row_rd[0], search_age_ff);
      for (int i = 1; i < WAYS; i++) begin
         cur_val = repl_worth(row_rd[i], search_age_ff);
         if (cur_val < best_val) begin
            best_val = cur_val;
            best_e   = row_rd[i];
            best_idx = WAY_W'(i);
         end
      end
   end

   // save: keep the move unless a new one is given or the tag differs; overwrite when more valuable
   always_comb begin
      way_ok = (int'(way_ff) < WAYS);
      sel_e  = row_rd[0];
      for (int i = 0; i < WAYS; i++) begin
         if (way_ff == WAY_W'(i)) begin
            sel_e = row_rd[i];
         end
      end
      save_e   = sel_e;
      tag_diff = (sel_e.tag != key_tag_ff);
      deeper   = $signed({2'b00, depth8_ff}) > ($signed({2'b00, sel_e.depth}) - 10'sd4);
      if (move_ff != 16'd0 || tag_diff) begin
         save_e.move = move_ff;
      end
      if (tag_diff || deeper || bound_ff == BOUND_KIND_EXACT) begin
         save_e.tag   = key_tag_ff;
         save_e.value = score_ff;
         save_e.eval  = eval_ff;
         save_e.depth = depth8_ff;
         save_e.age   = search_age_ff;
         save_e.pv    = pv_ff;
         save_e.bound = bound_ff;
      end
   end

   always_comb begin
      row_new      = row_rd;
      res_hit_in   = 1'b0;
      res_way_in   = way_ff;
      res_entry_in = '0;
      if (opcode_ff == OP_PROBE) begin
         if (found) begin
            for (int i = 0; i < WAYS; i++) begin
               if (found_idx == WAY_W'(i)) begin
                  row_new[i] = found_e;
               end
            end
            res_hit_in   = (found_e.tag != 16'd0);
            res_way_in   = found_idx;
            res_entry_in = found_e;
         end else begin
            res_way_in   = best_idx;
            res_entry_in = best_e;
         end
      end else if (way_ok) begin
         for (int i = 0; i < WAYS; i++) begin
            if (way_ff == WAY_W'(i)) begin
               row_new[i] = save_e;
            end
         end
         res_entry_in = save_e;
      end
   end

   assign rsp_hit         = res_hit_ff;
   assign rsp_chosen_way  = res_way_ff;
   assign rsp_entry_tag   = res_entry_ff.tag;
   assign rsp_entry_move  = res_entry_ff.move;
   assign rsp_entry_value = res_entry_ff.value;
   assign rsp_entry_eval  = res_entry_ff.eval;
   assign rsp_entry_depth = res_entry_ff.depth;
   assign rsp_entry_bound = res_entry_ff.bound;
   assign rsp_entry_pv    = res_entry_ff.pv;
   assign rsp_entry_age   = res_entry_ff.age;

   // a hit always carries the probed nonzero tag
   a_hit_tag: assert property (@(posedge clock) disable iff (reset)
      (cmd.commit && res_hit_in) |-> (res_entry_in.tag != 16'd0 &&
                                      res_entry_in.tag == key_tag_ff))
      else $error("hit reported on a non-matching way");

   // saves never report a hit
   a_save_no_hit: assert property (@(posedge clock) disable iff (reset)
      (cmd.commit && opcode_ff == OP_SAVE) |=> !res_hit_ff)
      else $error("save reported a hit");

   // a probe always names a way inside the cluster
   a_probe_way: assert property (@(posedge clock) disable iff (reset)
      (cmd.commit && opcode_ff == OP_PROBE) |-> (int'(res_way_in) < WAYS))
      else $error("probe picked a way beyond the cluster");

endmodule

FILE: hdl/set_assoc_hash_table_depth_age.sv
// top level of the set-associative hash store with depth/age replacement
// depends on saht_pkg, saht_ctrl, saht_dp (which holds saht_ram)
//
// usage
//  - req_ channel: one transfer per probe or save (req_opcode), valid/ready
//  - rsp_ channel: one transfer per request, same order, valid/ready
//  - csr_wr_en/csr_wr_data: writes the search generation, no wait, write only
//    while no request is outstanding
//  - each cluster is one ram row holding all ways; the cluster index is
//    (key[31:0] * CLUSTERS) >> 32, registered at the request transfer
//  - result path: after the request transfer the ram read, then compare
//    and write back in one step
//  - one request at a time, no new one taken until the last is written
//    back, set by the single ram port pair and the read-then-write of the cluster row
//  - reset: the ram is swept to zero, one row per cycle, all CLUSTERS rows;
//    req_ready stays low until the sweep is done, csr writes are taken
//  - rsp stall: the result sits in the output register, the next request
//    is still taken and waits in the compare step until the result leaves
module set_assoc_hash_table_depth_age #(
   parameter int CLUSTERS   = 1024,
   parameter int WAYS       = 3,
   parameter int DEPTH_BIAS = -7
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  logic               req_opcode,
   input  logic [63:0]        req_key,
   input  logic [1:0]         req_target_way,
   input  logic signed [15:0] req_score,
   input  logic signed [15:0] req_static_eval,
   input  logic               req_pv_flag,
   input  logic [1:0]         req_bound_kind,
   input  logic signed [8:0]  req_search_depth,
   input  logic [15:0]        req_best_move,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic               rsp_hit,
   output logic [1:0]         rsp_chosen_way,
   output logic [15:0]        rsp_entry_tag,
   output logic [15:0]        rsp_entry_move,
   output logic signed [15:0] rsp_entry_value,
   output logic signed [15:0] rsp_entry_eval,
   output logic [7:0]         rsp_entry_depth,
   output logic [1:0]         rsp_entry_bound,
   output logic               rsp_entry_pv,
   output logic [4:0]         rsp_entry_age,
   input  logic               csr_wr_en,
   input  logic [4:0]         csr_wr_data
);

   import saht_pkg::*;

   // command and status between sequencer and datapath
   cmd_type    cmd;
   status_type status;

   // sequencer: clear sweep, request transfer, ram read, commit
   saht_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .cmd       (cmd),
      .status    (status)
   );

   // datapath: cluster ram, way compare, save rules, result register
   saht_dp #(
      .CLUSTERS   (CLUSTERS),
      .WAYS       (WAYS),
      .DEPTH_BIAS (DEPTH_BIAS)
   ) u_dp (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .status           (status),
      .req_opcode       (req_opcode),
      .req_key          (req_key),
      .req_target_way   (req_target_way),
      .req_score        (req_score),
      .req_static_eval  (req_static_eval),
      .req_pv_flag      (req_pv_flag),
      .req_bound_kind   (req_bound_kind),
      .req_search_depth (req_search_depth),
      .req_best_move    (req_best_move),
      .csr_wr_en        (csr_wr_en),
      .csr_wr_data      (csr_wr_data),
      .rsp_hit          (rsp_hit),
      .rsp_chosen_way   (rsp_chosen_way),
      .rsp_entry_tag    (rsp_entry_tag),
      .rsp_entry_move   (rsp_entry_move),
      .rsp_entry_value  (rsp_entry_value),
      .rsp_entry_eval   (rsp_entry_eval),
      .rsp_entry_depth  (rsp_entry_depth),
      .rsp_entry_bound  (rsp_entry_bound),
      .rsp_entry_pv     (rsp_entry_pv),
      .rsp_entry_age    (rsp_entry_age)
   );

endmodule
